// ===== rtl/core/btb_pkg.sv =====
// ----------------------------------------------------------------------------
// btb_pkg: shared types and constants
// Command codes, register indexes and fixed field widths of the byte-rate
// token bucket.
// ----------------------------------------------------------------------------
package btb_pkg;

	localparam int CMD_W     = 2;
	localparam int REQ_W     = 32;   // request_bytes
	localparam int DEBT_W    = 32;
	localparam int LIMIT_W   = 40;   // limit_bps register
	localparam int REFILL_W  = 48;   // refill_per_tick register
	localparam int LEVEL_W   = 51;   // token level, fixed point
	localparam int WHOLE_W   = 35;   // tokens_whole output
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 48;

	// capacity = limit / 40 = (limit << (F-3)) / 5, burst = capacity_raw / 4
	localparam int CAP_SHIFT    = 3;
	localparam int CAP_DIVISOR  = 5;
	localparam int BURST_SHIFT  = 2;
	localparam int CAP_FLOOR    = 256;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK    = 2'd0,
		CMD_REQUEST = 2'd1,
		CMD_APPLY   = 2'd2,
		CMD_CANCEL  = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LIMIT  = 2'd0,
		REG_REFILL = 2'd1
	} reg_idx_t;

endpackage

// ===== rtl/core/btb_cap_div.sv =====
// ----------------------------------------------------------------------------
// btb_cap_div: bucket capacity and burst from the rate limit
// Division by five through a reciprocal multiply (four half-width partial
// products), a remainder step, then the capacity floor; the calculation
// reruns after every limit write.
// ----------------------------------------------------------------------------
module btb_cap_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [btb_pkg::LIMIT_W-1:0]        limit,
	output logic                               busy,
	output logic [btb_pkg::LIMIT_W+FRAC_BITS-btb_pkg::CAP_SHIFT-1:0] cap,
	output logic [btb_pkg::LIMIT_W+FRAC_BITS-btb_pkg::CAP_SHIFT-1:0] burst
);
	import btb_pkg::*;

	localparam int CW  = LIMIT_W + FRAC_BITS - CAP_SHIFT;
	localparam int HW  = LIMIT_W / 2;      // partial product operand width
	localparam int AW  = 2 * LIMIT_W;      // full product width
	localparam int RSH = LIMIT_W + 2;      // reciprocal scale, exact below 2^LIMIT_W
	localparam int QW  = AW - RSH;         // limit / 5 fits here
	localparam int FSH = FRAC_BITS - CAP_SHIFT;
	localparam logic [63:0] RECIP64 =
		((64'd1 << RSH) + 64'(CAP_DIVISOR - 1)) / 64'(CAP_DIVISOR);
	localparam logic [LIMIT_W-1:0] RECIP = RECIP64[LIMIT_W-1:0];
	localparam logic [CW-1:0] FLOOR = CW'(CAP_FLOOR) << FRAC_BITS;
	// fraction bits contributed by a remainder of one to four
	localparam logic [CW-1:0] TAIL1 = CW'((64'd1 << FSH) / 64'(CAP_DIVISOR));
	localparam logic [CW-1:0] TAIL2 = CW'((64'd2 << FSH) / 64'(CAP_DIVISOR));
	localparam logic [CW-1:0] TAIL3 = CW'((64'd3 << FSH) / 64'(CAP_DIVISOR));
	localparam logic [CW-1:0] TAIL4 = CW'((64'd4 << FSH) / 64'(CAP_DIVISOR));
	localparam logic [2:0] LAST_MUL = 3'd3;
	localparam logic [2:0] STEP_REM = 3'd4;
	localparam logic [2:0] STEP_END = 3'd5;

	logic               busy_q;
	logic [2:0]         step_q;
	logic [LIMIT_W-1:0] lim_q;
	logic [AW-1:0]      acc_q;
	logic [QW-1:0]      quo_q;
	logic [2:0]         rem_q;
	logic [CW-1:0]      cap_q;
	logic [CW-1:0]      burst_q;

	logic [HW-1:0]      a_sel;
	logic [HW-1:0]      m_sel;
	logic [LIMIT_W-1:0] prod;
	logic [AW-1:0]      pp;
	logic [QW-1:0]      quo;
	logic [LIMIT_W-1:0] back;
	logic [LIMIT_W-1:0] rem_full;
	logic [CW-1:0]      tail;
	logic [CW-1:0]      raw;

	always_comb begin
		case (step_q)
			3'd0: begin
				a_sel = lim_q[HW-1:0];
				m_sel = RECIP[HW-1:0];
			end
			3'd1: begin
				a_sel = lim_q[HW-1:0];
				m_sel = RECIP[LIMIT_W-1:HW];
			end
			3'd2: begin
				a_sel = lim_q[LIMIT_W-1:HW];
				m_sel = RECIP[HW-1:0];
			end
			default: begin
				a_sel = lim_q[LIMIT_W-1:HW];
				m_sel = RECIP[LIMIT_W-1:HW];
			end
		endcase
		prod = LIMIT_W'(a_sel) * LIMIT_W'(m_sel);
		case (step_q)
			3'd0:       pp = AW'(prod);
			3'd1, 3'd2: pp = AW'(prod) << HW;
			default:    pp = AW'(prod) << LIMIT_W;
		endcase

		quo      = acc_q[AW-1:RSH];
		back     = LIMIT_W'({quo, 2'b00}) + LIMIT_W'(quo);   // 5 * quotient
		rem_full = lim_q - back;

		case (rem_q)
			3'd1:    tail = TAIL1;
			3'd2:    tail = TAIL2;
			3'd3:    tail = TAIL3;
			3'd4:    tail = TAIL4;
			default: tail = '0;
		endcase
		raw = (CW'(quo_q) << FSH) + tail;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			step_q  <= '0;
			cap_q   <= '0;
			burst_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 3'd1;
			if (step_q == STEP_END) begin
				busy_q  <= 1'b0;
				cap_q   <= (raw > FLOOR) ? raw : FLOOR;
				burst_q <= raw >> BURST_SHIFT;   // never above the capacity
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			lim_q <= limit;
			acc_q <= '0;
		end else if (busy_q) begin
			if (step_q <= LAST_MUL) begin
				acc_q <= acc_q + pp;
			end
			if (step_q == STEP_REM) begin
				quo_q <= quo;
				rem_q <= rem_full[2:0];
			end
		end
	end

	assign busy  = busy_q;
	assign cap   = cap_q;
	assign burst = burst_q;

endmodule

// ===== rtl/core/byte_rate_token_bucket_unit.sv =====
// ----------------------------------------------------------------------------
// byte_rate_token_bucket_unit: token bucket byte-rate limiter
// Items pass the input register, then the result register once the output
// can advance; one item per cycle while out_ready holds. A limit_bps write
// starts a capacity calculation (four partial products, remainder, floor);
// in_ready and cfg_ready are low meanwhile.
// Reset (arst_n, async, low): tokens, debt and both registers cleared,
// limit reads as zero (unlimited), no item in flight.
// ----------------------------------------------------------------------------
module byte_rate_token_bucket_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// config write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [btb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [btb_pkg::CFG_DATA_W-1:0]    cfg_data,
	// input item channel
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [btb_pkg::CMD_W-1:0]         command,
	input  logic [btb_pkg::REQ_W-1:0]         request_bytes,
	// result item channel
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              done_res,
	output logic                              cancelled,
	output logic [btb_pkg::DEBT_W-1:0]        remaining,
	output logic [btb_pkg::WHOLE_W-1:0]       tokens_whole
);
	import btb_pkg::*;

	localparam int CW   = LIMIT_W + FRAC_BITS - CAP_SHIFT;  // capacity width
	localparam int EW   = (CW > LEVEL_W + 1) ? CW : LEVEL_W + 1;  // compare width
	localparam int WH_W = LEVEL_W - FRAC_BITS;              // whole tokens
	localparam int PW   = (WH_W > DEBT_W) ? WH_W : DEBT_W;  // paydown width
	localparam logic [EW-1:0] ONE_TOKEN = EW'(1) << FRAC_BITS;

	// ---------------- configuration ----------------
	logic          cfg_fire;
	logic          div_start;
	logic          div_busy;
	logic [CW-1:0] cap;
	logic [CW-1:0] burst;
	logic          lim_zero_q;
	logic [REFILL_W-1:0] refill_q;

	assign cfg_ready = !div_busy;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign div_start = cfg_fire && (cfg_index == REG_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_zero_q <= 1'b1;
			refill_q   <= '0;
		end else if (cfg_fire) begin
			case (reg_idx_t'(cfg_index))
				REG_LIMIT:  lim_zero_q <= (cfg_data[LIMIT_W-1:0] == '0);
				REG_REFILL: refill_q   <= cfg_data[REFILL_W-1:0];
				default: ;  // writes beyond the register list are dropped
			endcase
		end
	end

	btb_cap_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_cap_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.limit (cfg_data[LIMIT_W-1:0]),
		.busy  (div_busy),
		.cap   (cap),
		.burst (burst)
	);

	// ---------------- handshake ----------------
	// s1 is the input register; the step runs between s1 and the result regs.
	logic              s1_valid;
	cmd_t              cmd_s1;
	logic [REQ_W-1:0]  bytes_s1;
	logic              out_valid_q;
	logic              advance;
	logic              in_fire;

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !div_busy && (!s1_valid || advance);
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_fire) begin
			s1_valid <= 1'b1;
		end else if (advance) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_s1   <= cmd_t'(command);
			bytes_s1 <= request_bytes;
		end
	end

	// ---------------- step ----------------
	logic [LEVEL_W-1:0] level_q;
	logic [DEBT_W-1:0]  pend_q;

	logic [EW-1:0]      level_e;
	logic [EW-1:0]      cap_e;
	logic [EW-1:0]      sum_e;
	logic [EW-1:0]      clamp_e;
	logic [EW-1:0]      lv_e;
	logic [DEBT_W:0]    psum;
	logic [DEBT_W-1:0]  pend_n;
	logic               cancel_n;
	logic [LEVEL_W-1:0] lv1;
	logic [PW-1:0]      whole_p;
	logic [PW-1:0]      pend_p;
	logic [PW-1:0]      used;
	logic [LEVEL_W-1:0] lv2;
	logic [DEBT_W-1:0]  pend2;
	logic [LEVEL_W-1:0] whole_out;
	logic               done_n;

	always_comb begin
		level_e  = EW'(level_q);
		cap_e    = EW'(cap);
		sum_e    = level_e + EW'(refill_q);
		clamp_e  = (level_e > cap_e) ? cap_e : level_e;
		psum     = {1'b0, pend_q} + {1'b0, bytes_s1};
		lv_e     = level_e;
		pend_n   = pend_q;
		cancel_n = 1'b0;

		case (cmd_s1)
			CMD_TICK: begin
				if (!lim_zero_q) begin
					lv_e = (sum_e > cap_e) ? cap_e : sum_e;
				end
			end
			CMD_REQUEST: begin
				pend_n = psum[DEBT_W] ? '1 : psum[DEBT_W-1:0];  // saturate debt
			end
			CMD_APPLY: begin
				if (lim_zero_q) begin
					lv_e = '0;
				end else if (clamp_e < ONE_TOKEN) begin
					lv_e = EW'(burst);  // a bucket below one token gets the initial burst
				end else begin
					lv_e = clamp_e;
				end
			end
			default: begin  // cancel
				if (pend_q != '0) begin
					cancel_n = 1'b1;
					pend_n   = '0;
				end
			end
		endcase

		lv1 = lv_e[LEVEL_W-1:0];

		// pay the debt with whole tokens; with no limit the debt is cleared
		whole_p = PW'(lv1[LEVEL_W-1:FRAC_BITS]);
		pend_p  = PW'(pend_n);
		used    = (whole_p < pend_p) ? whole_p : pend_p;
		if (lim_zero_q) begin
			lv2   = lv1;
			pend2 = '0;
		end else begin
			lv2   = lv1 - (LEVEL_W'(used) << FRAC_BITS);
			pend2 = pend_n - DEBT_W'(used);
		end

		whole_out = lv2 >> FRAC_BITS;
		done_n    = (cmd_s1 != CMD_CANCEL) && (pend2 == '0)
			&& ((pend_q != '0) || (cmd_s1 == CMD_REQUEST));
	end

	// ---------------- state and result registers ----------------
	logic                done_q;
	logic                cancelled_q;
	logic [DEBT_W-1:0]   remaining_q;
	logic [WHOLE_W-1:0]  tokens_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= '0;
			pend_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (s1_valid && advance) begin
			level_q     <= lv2;
			pend_q      <= pend2;
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid && advance) begin
			done_q      <= done_n;
			cancelled_q <= cancel_n;
			remaining_q <= pend2;
			tokens_q    <= whole_out[WHOLE_W-1:0];
		end
	end

	assign out_valid    = out_valid_q;
	assign done_res     = done_q;
	assign cancelled    = cancelled_q;
	assign remaining    = remaining_q;
	assign tokens_whole = tokens_q;

endmodule

// ===== rtl/core/btb_checker.sv =====
// ----------------------------------------------------------------------------
// btb_checker: port-level checks for the token bucket
// Result flag consistency, output hold and busy after a limit write.
// ----------------------------------------------------------------------------
module btb_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           cfg_valid,
	input logic                           cfg_ready,
	input logic [btb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic                           done_res,
	input logic                           cancelled,
	input logic [btb_pkg::DEBT_W-1:0]     remaining,
	input logic [btb_pkg::WHOLE_W-1:0]    tokens_whole
);
	import btb_pkg::*;

	// a stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(remaining)
			&& $stable(tokens_whole) && $stable(done_res) && $stable(cancelled))
		else $error("result item changed while stalled");

	a_done_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> remaining == '0)
		else $error("done with debt left");

	a_cancel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cancelled |-> !done_res && remaining == '0)
		else $error("cancel result inconsistent");

	// capacity divide blocks items and config writes right after a limit write
	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && cfg_index == REG_LIMIT |=> !in_ready && !cfg_ready)
		else $error("item port open during capacity divide");

endmodule

bind byte_rate_token_bucket_unit btb_checker u_btb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cfg_valid   (cfg_valid),
	.cfg_ready   (cfg_ready),
	.cfg_index   (cfg_index),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.done_res    (done_res),
	.cancelled   (cancelled),
	.remaining   (remaining),
	.tokens_whole(tokens_whole)
);
